[sv/sprite_frame_sequencer_defines.svh]
// Assertion helpers shared by the sequencer RTL.
`ifndef SPRITE_FRAME_SEQUENCER_DEFINES_SVH
`define SPRITE_FRAME_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on clock and disabled in reset.
`define SFS_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled in reset.
`define SFS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/sfs_pkg.sv]
package sfs_pkg;

   localparam int FRAME_BITS    = 4;
   localparam int COUNT_BITS    = 5;
   localparam int CAP_BITS      = 40;
   localparam int FRAC_BITS     = 8;
   localparam int SPEED_BITS    = 16;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;
   localparam int RSP_DATA_BITS = 8;

   localparam logic [1:0] VIEW_FIRST = 2'd0;
   localparam logic [1:0] VIEW_HIDE  = 2'd1;
   localparam logic [1:0] VIEW_LAST  = 2'd2;

   typedef enum logic [1:0] {
      REQ_TICK,
      REQ_START,
      REQ_DELAY,
      REQ_SET_FRAME
   } req_kind_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_FRAME_COUNT,
      CSR_LOOP,
      CSR_PINGPONG,
      CSR_BACKWARD,
      CSR_FINISH_VIEW,
      CSR_SPEED
   } csr_index_type;

   typedef enum logic {
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } alu_sts_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_DIV_Q,
      S_MUL_STEPS,
      S_MUL_P,
      S_DIV_ADV,
      S_DIV_POS,
      S_FIN
   } seq_state_type;

endpackage

[sv/sprite_frame_sequencer.sv]
// Sprite animation frame sequencer. Every request beat yields exactly one response beat
// carrying the current frame, visibility, finished flag and whether the frame changed.
// Start, delay-write and set-frame requests, and a tick that finds the animation already
// finished, go from S_IDLE straight to S_FIN; a tick that finds the frame delay not yet
// elapsed passes through S_CHECK on its way to S_FIN. A tick that advances runs five
// operations back to back on one shared shift-and-add / shift-and-subtract unit that
// retires one bit per cycle; a tick that finishes the animation skips the last
// operation. While the response side stalls a waiting response beat, the sequencer
// holds in S_FIN until that beat is taken.
// The request side is not ready while a request is being worked on.
`include "sprite_frame_sequencer_defines.svh"

module sprite_frame_sequencer import sfs_pkg::*; #(
   parameter int MAX_FRAMES = 16,
   parameter int TIME_BITS  = 32,
   parameter int DELAY_BITS = 16,
   localparam int REQ_DW = ((TIME_BITS + FRAME_BITS + DELAY_BITS + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DW-1:0]        req_tdata,  // now_time, frame_index, delay_value
   input  logic [1:0]               req_tuser,  // req_type
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,  // shown_frame, visible, done_res,
                                                // frame_changed
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int EW  = (TIME_BITS < CAP_BITS) ? TIME_BITS : CAP_BITS;
   localparam int SW  = EW + SPEED_BITS - FRAC_BITS;
   localparam int PW  = SW + DELAY_BITS;
   localparam int AW  = PW + FRAC_BITS;
   localparam int BW  = (DELAY_BITS > SPEED_BITS) ? DELAY_BITS : SPEED_BITS;
   localparam int CW  = $clog2(AW + 1);
   localparam int MW  = SW + 1;
   localparam int AIW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

   logic [COUNT_BITS-1:0] fc_ff;
   logic                  loop_ff;
   logic                  pp_ff;
   logic                  back_cfg_ff;
   logic [1:0]            view_ff;
   logic [SPEED_BITS-1:0] spd_ff;

   seq_state_type           state_ff, state_in;
   logic [FRAME_BITS-1:0]   cur_ff, cur_in;
   logic                    dir_ff, dir_in;
   logic [TIME_BITS-1:0]    lut_ff, lut_in;
   logic                    fin_ff, fin_in;
   logic                    shown_ff, shown_in;
   logic [TIME_BITS-1:0]    now_ff, now_in;
   logic [FRAME_BITS-1:0]   before_ff, before_in;
   logic [DELAY_BITS-1:0]   d_ff, d_in;
   logic [SW-1:0]           steps_ff, steps_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic [DELAY_BITS-1:0] delay_mem [MAX_FRAMES];
   logic [DELAY_BITS-1:0] rd_ff;

   logic [TIME_BITS-1:0]          req_now;
   logic [FRAME_BITS-1:0]         req_idx;
   logic [DELAY_BITS-1:0]         req_dly;
   req_kind_type                  kind;
   logic                          accept;
   logic                          mem_we;
   logic [AIW+FRAME_BITS-1:0]     wr_ext;
   logic [AIW+FRAME_BITS-1:0]     rd_ext;
   logic [COUNT_BITS-1:0]         n;
   logic [SPEED_BITS-1:0]         spd_eff;
   logic [DELAY_BITS-1:0]         d_eff;
   logic [TIME_BITS-1:0]          elapsed;
   logic                          cap_hit;
   logic [EW-1:0]                 el_c;
   logic [MW-1:0]                 pos_fwd;
   logic                          back_neg;
   logic                          at_end;
   logic [MW-1:0]                 mag;
   logic [COUNT_BITS-1:0]         r;
   logic [COUNT_BITS-1:0]         nxt;

   alu_cmd_type   alu_cmd;
   alu_sts_type   alu_sts;
   logic [AW-1:0] alu_a;
   logic [BW-1:0] alu_b;
   logic [CW-1:0] alu_cnt;
   logic [AW-1:0] alu_res;
   logic [BW-1:0] alu_rem;

   sfs_alu #(
      .AW(AW),
      .BW(BW)
   ) u_alu (
      .clock     (clock),
      .reset     (reset),
      .cmd       (alu_cmd),
      .opa       (alu_a),
      .opb       (alu_b),
      .count     (alu_cnt),
      .sts       (alu_sts),
      .result    (alu_res),
      .remainder (alu_rem)
   );

   assign req_now    = req_tdata[TIME_BITS-1:0];
   assign req_idx    = req_tdata[TIME_BITS +: FRAME_BITS];
   assign req_dly    = req_tdata[TIME_BITS + FRAME_BITS +: DELAY_BITS];
   assign kind       = req_kind_type'(req_tuser);
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign mem_we     = accept && (kind == REQ_DELAY) && (int'(req_idx) < MAX_FRAMES);
   assign wr_ext     = {{AIW{1'b0}}, req_idx};
   assign rd_ext     = {{AIW{1'b0}}, cur_ff};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         delay_mem[wr_ext[AIW-1:0]] <= req_dly;
      end
      rd_ff <= delay_mem[rd_ext[AIW-1:0]];
   end

   always_comb begin
      if (fc_ff == '0) begin
         n = COUNT_BITS'(1);
      end else if (int'(fc_ff) > MAX_FRAMES) begin
         n = COUNT_BITS'(MAX_FRAMES);
      end else begin
         n = fc_ff;
      end
      spd_eff  = (spd_ff == '0) ? SPEED_BITS'(1) : spd_ff;
      d_eff    = (rd_ff == '0) ? DELAY_BITS'(1) : rd_ff;
      elapsed  = now_ff - lut_ff;
      cap_hit  = (TIME_BITS > EW) && ((elapsed >> EW) != '0);
      el_c     = cap_hit ? '1 : elapsed[EW-1:0];
      pos_fwd  = MW'(steps_ff) + MW'(cur_ff);
      back_neg = steps_ff > SW'(cur_ff);
      at_end   = dir_ff ? back_neg : (pos_fwd >= MW'(n));
      if (!dir_ff) begin
         mag = pos_fwd;
      end else if (back_neg) begin
         mag = MW'(steps_ff) - MW'(cur_ff);
      end else begin
         mag = MW'(cur_ff) - MW'(steps_ff);
      end
      r = alu_rem[COUNT_BITS-1:0];
      if (pp_ff && at_end) begin
         if (!dir_ff) begin
            nxt = ((r + COUNT_BITS'(2)) > n) ? '0 : (n - r - COUNT_BITS'(2));
         end else begin
            nxt = r;
         end
      end else if (dir_ff && back_neg && (r != '0)) begin
         nxt = n - r;
      end else begin
         nxt = r;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      dir_in       = dir_ff;
      lut_in       = lut_ff;
      fin_in       = fin_ff;
      shown_in     = shown_ff;
      now_in       = now_ff;
      before_in    = before_ff;
      d_in         = d_ff;
      steps_in     = steps_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      alu_cmd      = '{start: 1'b0, op: ALU_DIV};
      alu_a        = '0;
      alu_b        = '0;
      alu_cnt      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               before_in = cur_ff;
               now_in    = req_now;
               state_in  = S_FIN;
               unique case (kind)
                  REQ_TICK: begin
                     if (!fin_ff) begin
                        state_in = S_CHECK;
                     end
                  end
                  REQ_START: begin
                     shown_in = 1'b1;
                     fin_in   = 1'b0;
                     lut_in   = req_now;
                     dir_in   = back_cfg_ff;
                  end
                  REQ_DELAY: begin
                  end
                  REQ_SET_FRAME: begin
                     if (COUNT_BITS'(req_idx) < n) begin
                        cur_in = req_idx;
                     end
                  end
               endcase
            end
         end
         S_CHECK: begin
            d_in = d_eff;
            if (64'(elapsed) < 64'(d_eff)) begin
               state_in = S_FIN;
            end else begin
               alu_cmd  = '{start: 1'b1, op: ALU_DIV};
               alu_a    = AW'(el_c) << (AW - EW);
               alu_b    = BW'(d_eff);
               alu_cnt  = CW'(EW);
               state_in = S_DIV_Q;
            end
         end
         S_DIV_Q: begin
            if (alu_sts.done) begin
               alu_cmd  = '{start: 1'b1, op: ALU_MUL};
               alu_a    = AW'(alu_res[EW-1:0]);
               alu_b    = BW'(spd_eff);
               alu_cnt  = CW'(BW);
               state_in = S_MUL_STEPS;
            end
         end
         S_MUL_STEPS: begin
            if (alu_sts.done) begin
               steps_in = alu_res[SW+FRAC_BITS-1:FRAC_BITS];
               alu_cmd  = '{start: 1'b1, op: ALU_MUL};
               alu_a    = AW'(alu_res[SW+FRAC_BITS-1:FRAC_BITS]);
               alu_b    = BW'(d_ff);
               alu_cnt  = CW'(BW);
               state_in = S_MUL_P;
            end
         end
         S_MUL_P: begin
            if (alu_sts.done) begin
               alu_cmd  = '{start: 1'b1, op: ALU_DIV};
               alu_a    = {alu_res[PW-1:0], {FRAC_BITS{1'b0}}};
               alu_b    = BW'(spd_eff);
               alu_cnt  = CW'(AW);
               state_in = S_DIV_ADV;
            end
         end
         S_DIV_ADV: begin
            if (alu_sts.done) begin
               lut_in = lut_ff + alu_res[TIME_BITS-1:0];
               if (at_end && !loop_ff && (!pp_ff || dir_ff)) begin
                  fin_in = 1'b1;
                  if (view_ff == VIEW_FIRST) begin
                     cur_in = '0;
                  end else if (view_ff == VIEW_HIDE) begin
                     shown_in = 1'b0;
                  end else begin
                     cur_in = FRAME_BITS'(n - COUNT_BITS'(1));
                  end
                  state_in = S_FIN;
               end else begin
                  alu_cmd  = '{start: 1'b1, op: ALU_DIV};
                  alu_a    = AW'(mag) << (AW - MW);
                  alu_b    = BW'(n);
                  alu_cnt  = CW'(MW);
                  state_in = S_DIV_POS;
               end
            end
         end
         S_DIV_POS: begin
            if (alu_sts.done) begin
               cur_in = FRAME_BITS'(nxt);
               if (pp_ff && at_end) begin
                  dir_in = !dir_ff;
               end
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, cur_ff != before_ff, fin_ff, shown_ff, cur_ff};
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      before_ff   <= before_in;
      d_ff        <= d_in;
      steps_ff    <= steps_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= '0;
         dir_ff       <= 1'b0;
         lut_ff       <= '0;
         fin_ff       <= 1'b0;
         shown_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         dir_ff       <= dir_in;
         lut_ff       <= lut_in;
         fin_ff       <= fin_in;
         shown_ff     <= shown_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fc_ff       <= COUNT_BITS'(1);
         loop_ff     <= 1'b1;
         pp_ff       <= 1'b0;
         back_cfg_ff <= 1'b0;
         view_ff     <= VIEW_LAST;
         spd_ff      <= SPEED_BITS'(256);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_COUNT: fc_ff       <= csr_wdata[COUNT_BITS-1:0];
            CSR_LOOP:        loop_ff     <= csr_wdata[0];
            CSR_PINGPONG:    pp_ff       <= csr_wdata[0];
            CSR_BACKWARD:    back_cfg_ff <= csr_wdata[0];
            CSR_FINISH_VIEW: view_ff     <= csr_wdata[1:0];
            CSR_SPEED:       spd_ff      <= csr_wdata[SPEED_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `SFS_ASSERT_NEXT(a_accept_leaves_idle, req_tvalid && req_tready, state_ff != S_IDLE,
      "request beat accepted but sequencer stayed idle")
   `SFS_ASSERT_IMPL(a_alu_start_free, alu_cmd.start, !alu_sts.busy,
      "shared unit started while busy")
   `SFS_ASSERT_NEXT(a_frame_in_range, state_ff == S_DIV_POS && alu_sts.done,
      COUNT_BITS'(cur_ff) < n, "advanced frame outside the frames in use")

endmodule

[sv/sfs_alu.sv]
module sfs_alu import sfs_pkg::*; #(
   parameter int AW = 88,
   parameter int BW = 16,
   localparam int CW = $clog2(AW + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  alu_cmd_type   cmd,
   input  logic [AW-1:0] opa,
   input  logic [BW-1:0] opb,
   input  logic [CW-1:0] count,
   output alu_sts_type   sts,
   output logic [AW-1:0] result,
   output logic [BW-1:0] remainder
);

   logic [AW-1:0] acc_ff, acc_in;
   logic [AW-1:0] mcand_ff, mcand_in;
   logic [BW-1:0] b_ff, b_in;
   logic [BW-1:0] rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   alu_op_type    op_ff, op_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;

   logic [BW:0]   shifted;
   logic [BW:0]   diff;
   logic [AW-1:0] addend;
   logic [AW-1:0] sum;

   always_comb begin
      shifted = {rem_ff, acc_ff[AW-1]};
      diff    = shifted - {1'b0, b_ff};
      addend  = b_ff[BW-1] ? mcand_ff : '0;
      sum     = {acc_ff[AW-2:0], 1'b0} + addend;

      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      b_in     = b_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      op_in    = op_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;

      if (cmd.start) begin
         acc_in   = (cmd.op == ALU_DIV) ? opa : '0;
         mcand_in = opa;
         b_in     = opb;
         rem_in   = '0;
         cnt_in   = count;
         op_in    = cmd.op;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         unique case (op_ff)
            ALU_DIV: begin
               if (shifted >= {1'b0, b_ff}) begin
                  rem_in = diff[BW-1:0];
                  acc_in = {acc_ff[AW-2:0], 1'b1};
               end else begin
                  rem_in = shifted[BW-1:0];
                  acc_in = {acc_ff[AW-2:0], 1'b0};
               end
            end
            ALU_MUL: begin
               acc_in = sum;
               b_in   = {b_ff[BW-2:0], 1'b0};
            end
         endcase
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      b_ff     <= b_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      op_ff    <= op_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.busy  = busy_ff;
   assign sts.done  = done_ff;
   assign result    = acc_ff;
   assign remainder = rem_ff;

endmodule

[bench/tb_sprite_frame_sequencer.sv]
`timescale 1ns / 100ps

module tb_sprite_frame_sequencer;
   import sfs_pkg::*;

   localparam int REQ_DW     = 56;
   localparam int IDLE_LIMIT = 6000;
   localparam int DRAIN_WAIT = 300;

   typedef struct packed {
      logic       changed;
      logic       done;
      logic       visible;
      logic [3:0] frame;
   } frame_status_type;

   class frame_scoreboard;
      logic [3:0]  cur_frame;
      bit          going_back;
      logic [31:0] update_stamp;
      bit          finished;
      bit          shown;
      logic [15:0] delays [16];
      logic [4:0]  cfg_count;
      bit          cfg_loop;
      bit          cfg_pingpong;
      bit          cfg_backward;
      logic [1:0]  cfg_view;
      logic [15:0] cfg_speed;
      frame_status_type pending_status [$];
      int          errors;

      function new();
         cur_frame = '0;
         going_back = 0;
         update_stamp = '0;
         finished = 0;
         shown = 1;
         cfg_count = 5'd1;
         cfg_loop = 1;
         cfg_pingpong = 0;
         cfg_backward = 0;
         cfg_view = VIEW_LAST;
         cfg_speed = 16'd256;
         errors = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [15:0] value);
         case (idx)
            CSR_FRAME_COUNT: cfg_count = value[4:0];
            CSR_LOOP:        cfg_loop = value[0];
            CSR_PINGPONG:    cfg_pingpong = value[0];
            CSR_BACKWARD:    cfg_backward = value[0];
            CSR_FINISH_VIEW: cfg_view = value[1:0];
            CSR_SPEED:       cfg_speed = value;
            default: ;
         endcase
      endfunction

      function longint frames_used();
         longint n;
         n = cfg_count;
         if (n == 0) n = 1;
         if (n > 16) n = 16;
         return n;
      endfunction

      function void advance_frames(logic [31:0] now);
         longint n;
         longint unsigned d, elapsed, q, spd, steps, p, adv;
         longint pos, nxt;
         logic [31:0] diff;
         bit at_end;
         n = frames_used();
         if (finished) return;
         d = delays[cur_frame];
         if (d == 0) d = 1;
         diff = now - update_stamp;
         elapsed = diff;
         if (elapsed < d) return;
         spd = (cfg_speed == 0) ? 1 : cfg_speed;
         q = elapsed / d;
         steps = (q * spd) >> 8;
         p = steps * d;
         adv = (p / spd) * 256 + ((p % spd) * 256) / spd;
         update_stamp = update_stamp + adv[31:0];
         pos = going_back ? longint'(cur_frame) - longint'(steps)
                          : longint'(cur_frame) + longint'(steps);
         at_end = going_back ? (pos <= -1) : (pos >= n);
         if (at_end && !cfg_loop && (!cfg_pingpong || going_back)) begin
            finished = 1;
            if (cfg_view == VIEW_FIRST) cur_frame = '0;
            else if (cfg_view == VIEW_HIDE) shown = 0;
            else cur_frame = 4'(n - 1);
            return;
         end
         nxt = pos % n;
         if (nxt < 0) nxt += n;
         if (cfg_pingpong && at_end) begin
            if (!going_back) begin
               nxt = n - nxt - 2;
               if (nxt < 0) nxt = 0;
            end else begin
               nxt = (-pos) % n;
            end
            going_back = !going_back;
         end
         if (nxt < 0 || nxt >= n) nxt = 0;
         cur_frame = nxt[3:0];
      endfunction

      function void note_request(req_kind_type kind, logic [31:0] now, logic [3:0] idx,
                                 logic [15:0] dly);
         logic [3:0] prior;
         frame_status_type st;
         prior = cur_frame;
         case (kind)
            REQ_TICK: advance_frames(now);
            REQ_START: begin
               shown = 1;
               finished = 0;
               update_stamp = now;
               going_back = cfg_backward;
            end
            REQ_DELAY: delays[idx] = dly;
            REQ_SET_FRAME: if (longint'(idx) < frames_used()) cur_frame = idx;
            default: ;
         endcase
         st.frame = cur_frame;
         st.visible = shown;
         st.done = finished;
         st.changed = (cur_frame != prior);
         pending_status = {pending_status, st};
      endfunction

      function void check_result(logic [7:0] data);
         frame_status_type got, want;
         got = data[6:0];
         if (pending_status.size() == 0) begin
            $display("%0t: response beat with nothing expected: %h", $time, data);
            errors++;
            return;
         end
         want = pending_status.pop_front();
         if (got.frame !== want.frame) begin
            $display("%0t: shown_frame expected %0d actual %0d", $time, want.frame, got.frame);
            errors++;
         end
         if (got.visible !== want.visible) begin
            $display("%0t: visible expected %0b actual %0b", $time, want.visible, got.visible);
            errors++;
         end
         if (got.done !== want.done) begin
            $display("%0t: done_res expected %0b actual %0b", $time, want.done, got.done);
            errors++;
         end
         if (got.changed !== want.changed) begin
            $display("%0t: frame_changed expected %0b actual %0b", $time, want.changed,
                     got.changed);
            errors++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [REQ_DW-1:0]  req_tdata;
   logic [1:0]         req_tuser;
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic               csr_we;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   frame_scoreboard sb = new();
   int  idle_cycles;
   int  burst_left;
   int  ready_pct;
   int  hold_asks = 0;
   int  hold_taken = 0;
   int  hold_left = 0;
   logic [31:0] clock_ms;

   sprite_frame_sequencer DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.note_request(req_kind_type'(req_tuser), req_tdata[31:0], req_tdata[35:32],
                         req_tdata[51:36]);
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata);
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (hold_asks != hold_taken) begin
         hold_taken++;
         hold_left = 700;
         rsp_tready <= 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) < ready_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_request(req_kind_type kind, logic [31:0] now, logic [3:0] idx,
                               logic [15:0] dly);
      if (burst_left == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_tvalid <= 1;
      req_tuser <= kind;
      req_tdata <= {4'b0, dly, idx, now};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_csr(csr_index_type idx, logic [15:0] value);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      sb.write_register(idx, value);
      @(posedge clock);
      csr_we <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending_status.size() > 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic random_request();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 58) begin
         if ($urandom_range(0, 99) < 3) clock_ms = $urandom;
         else clock_ms = clock_ms + $urandom_range(0, 60);
         send_request(REQ_TICK, clock_ms, 4'($urandom), 16'($urandom));
      end else if (pick < 68) begin
         send_request(REQ_START, clock_ms, 4'($urandom), 16'($urandom));
      end else if (pick < 82) begin
         send_request(REQ_DELAY, $urandom, 4'($urandom),
                      ($urandom_range(0, 19) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 25)));
      end else begin
         send_request(REQ_SET_FRAME, $urandom, 4'($urandom), 16'($urandom));
      end
   endtask

   initial begin
      logic [15:0] setting [6];
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      req_tuser = REQ_TICK;
      csr_we = 0;
      csr_index = CSR_FRAME_COUNT;
      csr_wdata = '0;
      burst_left = 0;
      ready_pct = 100;
      clock_ms = 0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Every frame delay is written before any tick can read it.
      send_request(REQ_DELAY, 0, 0, 0);
      for (int i = 1; i < 15; i++) send_request(REQ_DELAY, 0, 4'(i), 16'(i));
      send_request(REQ_DELAY, 32'hFFFF_FFFF, 4'd15, 16'hFFFF);
      send_request(REQ_START, 0, 0, 0);
      send_request(REQ_TICK, 0, 0, 0);
      send_request(REQ_TICK, 5, 0, 0);
      send_request(REQ_SET_FRAME, 0, 4'd15, 0);
      send_request(REQ_TICK, 32'hFFFF_FFFF, 0, 0);
      send_request(REQ_START, 32'hFFFF_FFF0, 0, 0);
      send_request(REQ_TICK, 32'h0000_0010, 0, 0);
      send_request(REQ_SET_FRAME, 0, 0, 0);
      send_request(REQ_TICK, 32'h8000_0000, 0, 0);
      drain();

      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0: setting = '{16, 1, 0, 0, 2, 256};
            1: setting = '{16, 0, 0, 0, 0, 512};
            2: setting = '{5, 0, 1, 0, 1, 256};
            3: setting = '{16, 0, 1, 1, 2, 65535};
            4: setting = '{1, 0, 0, 1, 1, 0};
            5: setting = '{7, 1, 1, 1, 0, 100};
            6: setting = '{16, 0, 0, 1, 2, 1024};
            7: setting = '{3, 0, 1, 0, 2, 384};
            default: setting = '{$urandom_range(1, 16), $urandom_range(0, 1),
                                 $urandom_range(0, 1), $urandom_range(0, 1),
                                 $urandom_range(0, 2), $urandom_range(0, 2048)};
         endcase
         for (int r = 0; r < 6; r++) write_csr(csr_index_type'(r), setting[r]);
         ready_pct = (phase % 3 == 0) ? 100 : $urandom_range(30, 90);
         send_request(REQ_START, clock_ms, 0, 0);
         for (int k = 0; k < 150; k++) begin
            if (phase == 2 && k == 20) hold_asks++;
            random_request();
         end
         drain();
      end

      if (sb.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule
